// ===== hdl/bbrf_pkg.sv =====
`default_nettype none
package bbrf_pkg;

  localparam int CAPACITY    = 1024;
  localparam int DATA_W      = 64;
  localparam int COUNT_W     = 4;
  localparam int FILL_W      = 11;
  localparam int BANKS       = 8;
  localparam int BANK_W      = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Work handed from the front to the back; the store pointer travels beside it.
  typedef struct packed {
    kind_t               kind;
    logic [COUNT_W-1:0]  cnt;
    status_t             status;
    logic [FILL_W-1:0]   fill;
    logic [DATA_W-1:0]   data;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/bbrf_ram.sv =====
`default_nettype none
module bbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bbrf_queue.sv =====
`default_nettype none
module bbrf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);

  localparam int PW = $clog2(DEPTH) + 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             push;
  logic             pop;

  // The extra pointer bit tells a full queue from an empty one.
  assign in_ready  = !((wr_ptr[PW-1] != rd_ptr[PW-1]) &&
                       (wr_ptr[PW-2:0] == rd_ptr[PW-2:0]));
  assign out_valid = (wr_ptr != rd_ptr);
  assign out_data  = slots[rd_ptr[PW-2:0]];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[PW-2:0]] <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bbrf_front.sv =====
`default_nettype none
module bbrf_front #(
  parameter int BURST_BYTES = 8,
  parameter int AW          = 10,
  parameter int CW          = 11
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire bbrf_pkg::action_t                action,
  input  wire logic [bbrf_pkg::DATA_W-1:0]      push_bytes,
  input  wire logic [bbrf_pkg::COUNT_W-1:0]     byte_count,
  output logic                                  q_valid,
  input  wire logic                             q_ready,
  output bbrf_pkg::cmd_t                        q_cmd,
  output logic      [AW-1:0]                    q_ptr
);

  logic [AW-1:0]                  head_index;
  logic [AW-1:0]                  tail_index;
  logic [CW-1:0]                  held_count;
  logic [AW-1:0]                  head_index_next;
  logic [AW-1:0]                  tail_index_next;
  logic [CW-1:0]                  held_count_next;
  logic [bbrf_pkg::COUNT_W-1:0]   cnt_sat;
  logic [bbrf_pkg::COUNT_W-1:0]   delivered;
  logic [CW-1:0]                  free_space;
  bbrf_pkg::status_t              status;
  bbrf_pkg::kind_t                kind;
  logic                           accept;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;

  always_comb begin
    cnt_sat = (byte_count > bbrf_pkg::COUNT_W'(BURST_BYTES)) ?
              bbrf_pkg::COUNT_W'(BURST_BYTES) : byte_count;
    free_space = CW'(bbrf_pkg::CAPACITY) - held_count;
    delivered  = (held_count < CW'(cnt_sat)) ?
                 held_count[bbrf_pkg::COUNT_W-1:0] : cnt_sat;
    head_index_next = head_index;
    tail_index_next = tail_index;
    held_count_next = held_count;
    status          = bbrf_pkg::ST_OK;
    kind            = bbrf_pkg::KIND_NONE;
    q_ptr           = head_index;
    q_cmd.cnt       = '0;
    case (action)
      bbrf_pkg::ACT_PUSH: begin
        q_ptr = tail_index;
        if (free_space < CW'(cnt_sat)) begin
          status = bbrf_pkg::ST_OVERFLOW;
        end else begin
          kind            = bbrf_pkg::KIND_WRITE;
          q_cmd.cnt       = cnt_sat;
          tail_index_next = tail_index + AW'(cnt_sat);
          held_count_next = held_count + CW'(cnt_sat);
        end
      end
      bbrf_pkg::ACT_POP, bbrf_pkg::ACT_PEEK: begin
        if (held_count == '0) begin
          status = bbrf_pkg::ST_EMPTY;
        end else begin
          kind      = bbrf_pkg::KIND_READ;
          q_cmd.cnt = delivered;
          if (action == bbrf_pkg::ACT_POP) begin
            head_index_next = head_index + AW'(delivered);
            held_count_next = held_count - CW'(delivered);
          end
        end
      end
      bbrf_pkg::ACT_CLEAR: begin
        head_index_next = '0;
        tail_index_next = '0;
        held_count_next = '0;
      end
      default: begin
        status = bbrf_pkg::ST_OK;
      end
    endcase
    q_cmd.kind   = kind;
    q_cmd.status = status;
    q_cmd.fill   = bbrf_pkg::FILL_W'(held_count_next);
    q_cmd.data   = push_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      tail_index <= '0;
      held_count <= '0;
    end else if (accept) begin
      head_index <= head_index_next;
      tail_index <= tail_index_next;
      held_count <= held_count_next;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(bbrf_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && action == bbrf_pkg::ACT_CLEAR) |=>
      (held_count == '0 && head_index == '0 && tail_index == '0))
    else $error("clear left state behind");

  a_overflow_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && status == bbrf_pkg::ST_OVERFLOW) |=>
      ($stable(held_count) && $stable(tail_index)))
    else $error("overflowing push changed the queue");

endmodule
`default_nettype wire

// ===== hdl/bbrf_back.sv =====
`default_nettype none
module bbrf_back #(
  parameter int AW = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  output logic                                  q_ready,
  input  wire bbrf_pkg::cmd_t                   q_cmd,
  input  wire logic [AW-1:0]                    q_ptr,
  output logic                                  m_valid,
  input  wire logic                             m_ready,
  output bbrf_pkg::status_t                     m_status,
  output logic      [bbrf_pkg::DATA_W-1:0]      m_bytes,
  output logic      [bbrf_pkg::COUNT_W-1:0]     m_count,
  output logic      [bbrf_pkg::FILL_W-1:0]      m_fill
);

  localparam int RW   = AW - bbrf_pkg::BANK_W;
  localparam int ROWS = 1 << RW;

  logic                              issue;
  logic                              s1_ready;
  logic                              out_ready;
  logic                              s1_valid;
  logic                              s1_read;
  logic [bbrf_pkg::BANK_W-1:0]       s1_lo;
  logic [bbrf_pkg::COUNT_W-1:0]      s1_cnt;
  bbrf_pkg::status_t                 s1_status;
  logic [bbrf_pkg::FILL_W-1:0]       s1_fill;
  logic [7:0]                        rdata [bbrf_pkg::BANKS];
  logic [bbrf_pkg::DATA_W-1:0]       bytes_asm;

  assign out_ready = !m_valid || m_ready;
  assign s1_ready  = !s1_valid || out_ready;
  assign q_ready   = s1_ready;
  assign issue     = q_valid && s1_ready;

  // Byte k of a burst sits in bank (ptr + k) mod 8, so eight bytes move per access.
  for (genvar b = 0; b < bbrf_pkg::BANKS; b++) begin : g_bank
    logic [bbrf_pkg::BANK_W-1:0] off;
    logic [AW-1:0]               pos;
    logic                        we;
    logic                        re;

    assign off = bbrf_pkg::BANK_W'(b) - q_ptr[bbrf_pkg::BANK_W-1:0];
    assign pos = q_ptr + AW'(off);
    assign we  = issue && (q_cmd.kind == bbrf_pkg::KIND_WRITE) &&
                 (bbrf_pkg::COUNT_W'(off) < q_cmd.cnt);
    assign re  = issue && (q_cmd.kind == bbrf_pkg::KIND_READ);

    bbrf_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (pos[AW-1:bbrf_pkg::BANK_W]),
      .wdata (q_cmd.data[{off, 3'b000} +: 8]),
      .re    (re),
      .raddr (pos[AW-1:bbrf_pkg::BANK_W]),
      .rdata (rdata[b])
    );
  end

  always_comb begin
    for (int i = 0; i < bbrf_pkg::BANKS; i++) begin
      if (s1_read && (bbrf_pkg::COUNT_W'(i) < s1_cnt)) begin
        bytes_asm[8*i +: 8] = rdata[s1_lo + bbrf_pkg::BANK_W'(i)];
      end else begin
        bytes_asm[8*i +: 8] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_valid;
      end
      if (out_ready) begin
        m_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_read   <= (q_cmd.kind == bbrf_pkg::KIND_READ);
      s1_lo     <= q_ptr[bbrf_pkg::BANK_W-1:0];
      s1_cnt    <= q_cmd.cnt;
      s1_status <= q_cmd.status;
      s1_fill   <= q_cmd.fill;
    end
    if (out_ready && s1_valid) begin
      m_status <= s1_status;
      m_bytes  <= bytes_asm;
      m_count  <= s1_read ? s1_cnt : '0;
      m_fill   <= s1_fill;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/burst_byte_ring_fifo.sv =====
// Circular byte queue with burst push, pop, peek and clear.
// Requests enter on the s_ group: s_tuser carries the action, s_tdata the bytes
// to push and the byte count. Every request produces exactly one result on the
// m_ group: a status in m_tuser and, in m_tdata, the bytes returned by a pop or
// peek (oldest in the lowest byte), how many were returned and the fill level
// after the action.
// The front keeps the pointers and fill count and decides each request in the
// cycle it is accepted; a four-entry queue carries the decided work to the back,
// which writes or reads eight byte-wide RAM banks and packs the result.
// A request accepted by the front passes through the queue, the back's bank
// read stage and the result register before it shows on m_tvalid. One request
// is taken per cycle while the queue has room, one bank access per request.
// Reset empties the queue and drops any work in flight; the byte banks keep
// their contents and are not swept. When the receiver holds m_tready low the
// result register holds, the back stage and the queue fill up, and s_tready
// falls once the queue is full.
`default_nettype none
module burst_byte_ring_fifo #(
  parameter int BURST_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // push_bytes[63:0], byte_count[67:64], zero pad
  input  wire logic [1:0]  s_tuser,  // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [79:0] m_tdata,  // out_bytes[63:0], delivered_count[67:64],
                                     // fill_level[78:68], zero pad
  output logic      [1:0]  m_tuser   // status[1:0]
);

  localparam int AW = $clog2(bbrf_pkg::CAPACITY);
  localparam int CW = $clog2(bbrf_pkg::CAPACITY + 1);
  localparam int QW = $bits(bbrf_pkg::cmd_t) + AW;

  logic                              f_valid;
  logic                              f_ready;
  bbrf_pkg::cmd_t                    f_cmd;
  logic [AW-1:0]                     f_ptr;
  logic                              b_valid;
  logic                              b_ready;
  logic [QW-1:0]                     b_word;
  bbrf_pkg::status_t                 m_status;
  logic [bbrf_pkg::DATA_W-1:0]       m_bytes;
  logic [bbrf_pkg::COUNT_W-1:0]      m_count;
  logic [bbrf_pkg::FILL_W-1:0]       m_fill;

  bbrf_front #(
    .BURST_BYTES (BURST_BYTES),
    .AW          (AW),
    .CW          (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .action     (bbrf_pkg::action_t'(s_tuser)),
    .push_bytes (s_tdata[63:0]),
    .byte_count (s_tdata[67:64]),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_cmd      (f_cmd),
    .q_ptr      (f_ptr)
  );

  bbrf_queue #(
    .WIDTH (QW),
    .DEPTH (bbrf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cmd, f_ptr}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_word)
  );

  bbrf_back #(
    .AW (AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_cmd    (bbrf_pkg::cmd_t'(b_word[QW-1:AW])),
    .q_ptr    (b_word[AW-1:0]),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_status (m_status),
    .m_bytes  (m_bytes),
    .m_count  (m_count),
    .m_fill   (m_fill)
  );

  assign m_tdata = {1'b0, m_fill, m_count, m_bytes};
  assign m_tuser = m_status;

endmodule
`default_nettype wire
